// ===== src/ssga_pkg.sv =====
// ssga_pkg: beat types, command/status structs and fixed field widths
// for the steady-state GA block. No dependencies.
package ssga_pkg;

  localparam int FIELD_BITS   = 60;
  localparam int SLOT_BITS    = 4;
  localparam int FIT_OUT_BITS = 6;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_EVOLVE = 1'b1;

  typedef struct packed {
    logic                    operation;
    logic [SLOT_BITS-1:0]    slot;
    logic [FIELD_BITS-1:0]   genome;
    logic [SLOT_BITS-1:0]    parent_a;
    logic [SLOT_BITS-1:0]    parent_b;
    logic [FIELD_BITS-1:0]   cross_mask;
    logic [FIELD_BITS-1:0]   flip_mask;
  } in_t;

  typedef struct packed {
    logic                    status;
    logic [FIT_OUT_BITS-1:0] child_fitness;
    logic                    replaced;
    logic [FIT_OUT_BITS-1:0] best_fitness;
    logic [FIELD_BITS-1:0]   best_genome;
    logic                    solved;
  } out_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic rd_b;
    logic latch_a;
    logic mix;
    logic pop1;
    logic pop2;
    logic commit;
    logic scan_rd;
    logic finish;
  } ga_cmd_t;

  typedef struct packed {
    logic is_load;
    logic bad;
    logic do_scan;
    logic scan_last;
    logic out_free;
  } ga_sts_t;

endpackage

// ===== src/steady_state_ga_onemax.sv =====
// Steady-state GA on OneMax: one beat in, one result beat out. A new beat
// is accepted only once the last one is through. A load or an evolve that
// replaces rescans the fitness memory, one slot per cycle through its single
// registered read port; a rejected child and a beat with a bad slot or bad
// parents skip the rescan. Parents come one after the other from the genome
// memory's read port. A finished result waits in an output register while
// the next beat is taken. Depends on ssga_pkg, ssga_ctrl and ssga_dp.
module steady_state_ga_onemax #(
  parameter int GENOME_BITS = 60,
  parameter int POP_SIZE    = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ssga_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ssga_pkg::out_t out_data
);
  import ssga_pkg::*;

  ga_cmd_t cmd;
  ga_sts_t sts;

  ssga_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssga_dp #(
    .GENOME_BITS (GENOME_BITS),
    .POP_SIZE    (POP_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== src/ssga_dp.sv =====
// ssga_dp: datapath of the steady-state GA - genome and fitness memories,
// child build, two-stage popcount, best/worst tracking and output register.
// Depends on ssga_pkg.
module ssga_dp #(
  parameter int GENOME_BITS = 60,
  parameter int POP_SIZE    = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ssga_pkg::in_t    in_data,
  input  ssga_pkg::ga_cmd_t cmd,
  output ssga_pkg::ga_sts_t sts,
  input  logic             out_ready,
  output logic             out_valid,
  output ssga_pkg::out_t   out_data
);
  import ssga_pkg::*;

  localparam int GW  = (GENOME_BITS < FIELD_BITS) ? GENOME_BITS : FIELD_BITS;
  localparam int FW  = $clog2(GW + 1);
  localparam int IW  = $clog2(POP_SIZE);
  localparam int CW  = $clog2(POP_SIZE + 1);
  localparam int NCH = (GW + 7) / 8;
  localparam int PW  = NCH * 8;

  in_t               item_r;
  logic              bad_r;
  logic [GW-1:0]     child_r, child_nxt;
  logic [GW-1:0]     par_a_r;
  logic [3:0]        chunk_r [NCH];
  logic [3:0]        chunk_nxt [NCH];
  logic [FW-1:0]     fit_r;
  logic [FW-1:0]     fit_nxt;
  logic [IW-1:0]     worst_slot_r;
  logic [FW:0]       worst_fit_r;
  logic [GW-1:0]     best_bits_r;
  logic [FW-1:0]     best_score_r;
  logic              repl_r;
  logic [CW-1:0]     scan_cnt_r;
  logic              cmp_vld_r;
  logic [IW-1:0]     cmp_idx_r;

  logic [GW-1:0]     gmem [POP_SIZE];
  logic [FW-1:0]     fmem [POP_SIZE];
  logic [POP_SIZE-1:0] vld_r;
  logic [GW-1:0]     g_rd_r;
  logic              g_rd_vld_r;
  logic [FW-1:0]     f_rd_r;
  logic              f_rd_vld_r;

  out_t              out_r;
  logic              out_valid_r;

  logic              is_load;
  logic              bad_now;
  logic              accept;
  logic              do_write;
  logic [IW-1:0]     wr_addr;
  logic [IW-1:0]     g_addr;
  logic [IW-1:0]     f_addr;
  logic [GW-1:0]     g_eff;
  logic [FW:0]       f_eff;
  logic [PW-1:0]     child_pad;

  assign is_load = (item_r.operation == OP_LOAD);
  assign bad_now = is_load ? (32'(item_r.slot) >= 32'(POP_SIZE))
                           : ((item_r.parent_a == item_r.parent_b) ||
                              (32'(item_r.parent_a) >= 32'(POP_SIZE)) ||
                              (32'(item_r.parent_b) >= 32'(POP_SIZE)));
  assign accept   = ({1'b0, fit_r} >= worst_fit_r);
  assign do_write = cmd.commit && (is_load || accept);
  assign wr_addr  = is_load ? IW'(item_r.slot) : worst_slot_r;
  assign g_addr   = cmd.rd_b ? IW'(item_r.parent_b) : IW'(item_r.parent_a);
  assign f_addr   = scan_cnt_r[IW-1:0];
  assign g_eff    = g_rd_vld_r ? g_rd_r : '0;
  assign f_eff    = f_rd_vld_r ? {1'b0, f_rd_r} : '0;

  assign sts.is_load   = is_load;
  assign sts.bad       = bad_now;
  assign sts.do_scan   = is_load || accept;
  assign sts.scan_last = (scan_cnt_r == CW'(POP_SIZE - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  always_comb begin
    if (cmd.mix) begin
      child_nxt = ((par_a_r & ~item_r.cross_mask[GW-1:0]) |
                   (g_eff & item_r.cross_mask[GW-1:0])) ^ item_r.flip_mask[GW-1:0];
    end else begin
      child_nxt = item_r.genome[GW-1:0];
    end
  end

  // popcount: 8-bit chunks, then chunk sum
  assign child_pad = PW'(child_r);

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      chunk_nxt[c] = '0;
      for (int b = 0; b < 8; b++) begin
        chunk_nxt[c] = chunk_nxt[c] + {3'b000, child_pad[c*8+b]};
      end
    end
  end

  always_comb begin
    logic [7:0] sum;
    sum = '0;
    for (int c = 0; c < NCH; c++) begin
      sum = sum + {4'b0000, chunk_r[c]};
    end
    fit_nxt = FW'(sum);
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.decode) begin
      bad_r <= bad_now;
    end
    if ((cmd.decode && is_load) || cmd.mix) begin
      child_r <= child_nxt;
    end
    if (cmd.latch_a) begin
      par_a_r <= g_eff;
    end
    if (cmd.pop1) begin
      chunk_r <= chunk_nxt;
    end
    if (cmd.pop2) begin
      fit_r <= fit_nxt;
    end
    if (cmd.decode) begin
      repl_r <= 1'b0;
    end else if (cmd.commit && !is_load && accept) begin
      repl_r <= 1'b1;
    end
    if (cmd.commit) begin
      scan_cnt_r <= '0;
    end else if (cmd.scan_rd) begin
      scan_cnt_r <= scan_cnt_r + CW'(1);
    end
    cmp_idx_r <= f_addr;
    if (cmd.finish) begin
      out_r.status        <= bad_r;
      out_r.child_fitness <= bad_r ? '0 : FIT_OUT_BITS'(fit_r);
      out_r.replaced      <= repl_r;
      out_r.best_fitness  <= FIT_OUT_BITS'(best_score_r);
      out_r.best_genome   <= FIELD_BITS'(best_bits_r);
      out_r.solved        <= (32'(best_score_r) == 32'(GENOME_BITS));
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (do_write) begin
      gmem[wr_addr] <= child_r;
      fmem[wr_addr] <= fit_r;
    end
    g_rd_r     <= gmem[g_addr];
    g_rd_vld_r <= vld_r[g_addr];
    f_rd_r     <= fmem[f_addr];
    f_rd_vld_r <= vld_r[f_addr];
  end

  // state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      worst_slot_r <= '0;
      worst_fit_r  <= '0;
      best_bits_r  <= '0;
      best_score_r <= '0;
      cmp_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (do_write) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.commit && (fit_r > best_score_r)) begin
        best_score_r <= fit_r;
        best_bits_r  <= child_r;
      end
      if (cmd.commit && is_load) begin
        worst_fit_r <= '1;
      end else if (cmd.commit && accept) begin
        worst_fit_r <= {1'b0, fit_r};
      end else if (cmp_vld_r && (f_eff < worst_fit_r)) begin
        worst_slot_r <= cmp_idx_r;
        worst_fit_r  <= f_eff;
      end
      cmp_vld_r <= cmd.scan_rd;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_worst_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(worst_slot_r) < 32'(POP_SIZE))
    else $error("worst slot out of range");

  a_best_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(best_score_r) <= 32'(GW))
    else $error("best score above genome length");

  a_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
    do_write |=> vld_r[$past(wr_addr)])
    else $error("written slot not marked valid");

  a_repl_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.status && out_r.replaced))
    else $error("replacement flagged on a rejected beat");

endmodule

// ===== src/ssga_ctrl.sv =====
// ssga_ctrl: controller state machine of the steady-state GA; sequences
// decode, parent reads, popcount, commit, rescan and result hand-off.
// Depends on ssga_pkg.
module ssga_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ssga_pkg::ga_sts_t sts,
  output ssga_pkg::ga_cmd_t cmd
);
  import ssga_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DEC      = 10'b0000000010,
    S_RD_B     = 10'b0000000100,
    S_MIX      = 10'b0000001000,
    S_POP1     = 10'b0000010000,
    S_POP2     = 10'b0000100000,
    S_COMMIT   = 10'b0001000000,
    S_SCAN     = 10'b0010000000,
    S_SCAN_END = 10'b0100000000,
    S_FINISH   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.decode = 1'b1;
        if (sts.bad) begin
          state_nxt = S_FINISH;
        end else if (sts.is_load) begin
          state_nxt = S_POP1;
        end else begin
          state_nxt = S_RD_B;
        end
      end
      S_RD_B: begin
        cmd.rd_b    = 1'b1;
        cmd.latch_a = 1'b1;
        state_nxt   = S_MIX;
      end
      S_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = S_POP1;
      end
      S_POP1: begin
        cmd.pop1  = 1'b1;
        state_nxt = S_POP2;
      end
      S_POP2: begin
        cmd.pop2  = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = sts.do_scan ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
